### rtl/rcpa_pkg.sv
// shared constants, codes, types and search functions of the page allocator
package rcpa_pkg;

  localparam int PAGES       = 4096;
  localparam int COUNT_WIDTH = 8;

  localparam int PAGE_W    = $clog2(PAGES);
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WORDS     = PAGES / WORD_BITS;
  localparam int WORD_W    = $clog2(WORDS);

  localparam int REG_W     = 13;
  localparam int IDX_W     = 12;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [REG_W-1:0]       REG_MAX   = '1;

  localparam int FIRST_PAGE_RESET = 257;
  localparam int PAGE_COUNT_RESET = 4096;
  localparam int LIMIT_RESET = (PAGE_COUNT_RESET > PAGES) ? PAGES : PAGE_COUNT_RESET;
  localparam int FREE_RESET  = (FIRST_PAGE_RESET >= LIMIT_RESET) ? 0 :
                               LIMIT_RESET - FIRST_PAGE_RESET;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_ADDREF  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_NO_PAGES = 3'd1,
    STAT_RANGE    = 3'd2,
    STAT_UNREF    = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_PAGE = 1'b0,
    REG_PAGE_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_ALLOC0,
    S_ALLOC1,
    S_REF
  } state_t;

  // request into the occupancy bitmap
  typedef struct packed {
    logic                 clear;
    logic                 rd_en;
    logic [WORD_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WORD_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } bm_req_t;

  // view of the occupancy bitmap
  typedef struct packed {
    logic [WORD_BITS-1:0] rd_data;
    logic [WORDS-1:0]     full;
    logic                 clearing;
  } bm_stat_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } bit_hit_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] idx;
  } word_hit_t;

  // lowest clear bit of a bitmap word
  function automatic bit_hit_t first_zero_bit(input logic [WORD_BITS-1:0] v);
    bit_hit_t r;
    r.found = ~&v;
    r.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) r.idx = BIT_W'(i);
    end
    return r;
  endfunction

  // lowest word whose full flag is clear
  function automatic word_hit_t first_zero_word(input logic [WORDS-1:0] v);
    word_hit_t r;
    r.found = ~&v;
    r.idx   = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!v[i]) r.idx = WORD_W'(i);
    end
    return r;
  endfunction

endpackage

### rtl/refcounted_page_allocator.sv
// top level of the reference counted page allocator
//
// one command at a time: a command transfers when start is high and busy is low, and
// exactly one result follows on the result ports for a single cycle with done high;
// the receiver cannot stall, so results must be taken when done is seen. a range
// error or an allocate with no usable pages answers in the cycle after the transfer,
// release and add reference do a count and bitmap read, then a write back, and
// allocate reads the first bitmap word, then at most one more word found through
// the per-word full flags. clear waits for the bitmap clearing sweep of one 64-bit
// word per cycle; the same sweep runs after reset with busy high. the count store
// itself is never cleared: a page whose bitmap bit is low reads as count zero.
// configuration writes are always ready and are to be made only while no command
// is in flight.
module refcounted_page_allocator (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [rcpa_pkg::IDX_W-1:0]     page_index,
  // result channel
  output logic                           done,
  output logic [rcpa_pkg::STATUS_W-1:0]  status,
  output logic [rcpa_pkg::IDX_W-1:0]     result_page,
  output logic [rcpa_pkg::OUT_CNT_W-1:0] ref_count,
  output logic [rcpa_pkg::REG_W-1:0]     free_count,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcpa_pkg::REG_W-1:0]     cfg_data
);

  rcpa_pkg::state_t state, state_next;

  // configuration registers
  logic [rcpa_pkg::REG_W-1:0] first_page;
  logic [rcpa_pkg::REG_W-1:0] page_count;

  // free page counter
  logic [rcpa_pkg::REG_W-1:0] pages_free, free_next;

  // command held while in flight
  rcpa_pkg::op_t               op_q;
  logic [rcpa_pkg::IDX_W-1:0]  idx_q;
  logic [rcpa_pkg::WORD_W-1:0] word_q, word_next;

  // reference count store
  logic [rcpa_pkg::COUNT_WIDTH-1:0] cnt_mem [rcpa_pkg::PAGES];
  logic [rcpa_pkg::COUNT_WIDTH-1:0] cnt_rd;
  logic                             cnt_re, cnt_we;
  logic [rcpa_pkg::PAGE_W-1:0]      cnt_raddr, cnt_waddr;
  logic [rcpa_pkg::COUNT_WIDTH-1:0] cnt_wdata;

  // occupancy bitmap
  rcpa_pkg::bm_req_t  bm_req;
  rcpa_pkg::bm_stat_t bm_stat;

  // result to register
  logic                             resp_en;
  rcpa_pkg::status_t                resp_status;
  logic [rcpa_pkg::IDX_W-1:0]       resp_page;
  logic [rcpa_pkg::COUNT_WIDTH-1:0] resp_cnt;

  // derived limits
  logic [rcpa_pkg::REG_W-1:0] limit;
  logic [rcpa_pkg::REG_W-1:0] init_free;
  logic                       no_room;
  logic                       in_idx_ok;
  logic                       accept;

  // allocate search
  logic [rcpa_pkg::WORD_W-1:0]    w0;
  logic [rcpa_pkg::BIT_W-1:0]     b0;
  logic [rcpa_pkg::WORD_BITS-1:0] low_mask;
  logic [rcpa_pkg::WORDS-1:0]     upto_mask;
  rcpa_pkg::bit_hit_t             hit0, hit1;
  rcpa_pkg::word_hit_t            hit_w;
  logic                           alloc_try;
  logic [rcpa_pkg::WORD_W-1:0]    alloc_word;
  logic [rcpa_pkg::BIT_W-1:0]     alloc_bit;
  logic [rcpa_pkg::PAGE_W-1:0]    alloc_page;
  logic [rcpa_pkg::WORD_BITS-1:0] bit_onehot;

  // reference update
  logic [rcpa_pkg::BIT_W-1:0]       ref_bit;
  logic                             ref_used;
  logic [rcpa_pkg::COUNT_WIDTH-1:0] cnt_eff;
  logic [rcpa_pkg::COUNT_WIDTH-1:0] cnt_dec;
  logic [rcpa_pkg::COUNT_WIDTH:0]   cnt_inc;

  rcpa_bitmap u_bitmap (
    .clk  (clk),
    .rst  (rst),
    .req  (bm_req),
    .stat (bm_stat)
  );

  assign busy      = (state != rcpa_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // pages above the store size do not exist
  assign limit = (page_count > rcpa_pkg::REG_W'(rcpa_pkg::PAGES)) ?
                 rcpa_pkg::REG_W'(rcpa_pkg::PAGES) : page_count;
  assign no_room   = (first_page >= limit);
  assign init_free = no_room ? '0 : limit - first_page;
  assign in_idx_ok = ({1'b0, page_index} >= first_page) && ({1'b0, page_index} < limit);

  // first word of the search, bits below first_page count as taken
  assign w0        = first_page[rcpa_pkg::PAGE_W-1:rcpa_pkg::BIT_W];
  assign b0        = first_page[rcpa_pkg::BIT_W-1:0];
  assign low_mask  = (rcpa_pkg::WORD_BITS'(1) << b0) - rcpa_pkg::WORD_BITS'(1);
  assign upto_mask = (rcpa_pkg::WORDS'(2) << w0) - rcpa_pkg::WORDS'(1);
  assign hit0      = rcpa_pkg::first_zero_bit(bm_stat.rd_data | low_mask);
  assign hit_w     = rcpa_pkg::first_zero_word(bm_stat.full | upto_mask);
  assign hit1      = rcpa_pkg::first_zero_bit(bm_stat.rd_data);

  // a page whose bitmap bit is low has count zero whatever the store holds
  assign ref_bit  = idx_q[rcpa_pkg::BIT_W-1:0];
  assign ref_used = bm_stat.rd_data[ref_bit];
  assign cnt_eff  = ref_used ? cnt_rd : '0;
  assign cnt_dec  = cnt_eff - 1'b1;
  assign cnt_inc  = {1'b0, cnt_eff} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcpa_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    word_next   = word_q;
    free_next   = pages_free;
    bm_req      = '0;
    cnt_re      = 1'b0;
    cnt_raddr   = rcpa_pkg::PAGE_W'(page_index);
    cnt_we      = 1'b0;
    cnt_waddr   = rcpa_pkg::PAGE_W'(idx_q);
    cnt_wdata   = '0;
    resp_en     = 1'b0;
    resp_status = rcpa_pkg::STAT_OK;
    resp_page   = idx_q;
    resp_cnt    = '0;
    alloc_try   = 1'b0;
    alloc_word  = w0;
    alloc_bit   = hit0.idx;
    alloc_page  = '0;
    bit_onehot  = '0;

    case (state)
      rcpa_pkg::S_INIT: begin
        if (!bm_stat.clearing) state_next = rcpa_pkg::S_IDLE;
      end

      rcpa_pkg::S_IDLE: begin
        resp_page = page_index;
        if (start) begin
          case (rcpa_pkg::op_t'(opcode))
            rcpa_pkg::OP_CLEAR: begin
              bm_req.clear = 1'b1;
              state_next   = rcpa_pkg::S_CLEAR;
            end
            rcpa_pkg::OP_ALLOC: begin
              if (no_room) begin
                resp_en     = 1'b1;
                resp_status = rcpa_pkg::STAT_NO_PAGES;
              end else begin
                bm_req.rd_en   = 1'b1;
                bm_req.rd_addr = w0;
                state_next     = rcpa_pkg::S_ALLOC0;
              end
            end
            default: begin
              if (!in_idx_ok) begin
                resp_en     = 1'b1;
                resp_status = rcpa_pkg::STAT_RANGE;
              end else begin
                cnt_re         = 1'b1;
                bm_req.rd_en   = 1'b1;
                bm_req.rd_addr = rcpa_pkg::WORD_W'(page_index >> rcpa_pkg::BIT_W);
                state_next     = rcpa_pkg::S_REF;
              end
            end
          endcase
        end
      end

      rcpa_pkg::S_CLEAR: begin
        if (!bm_stat.clearing) begin
          free_next  = init_free;
          resp_en    = 1'b1;
          state_next = rcpa_pkg::S_IDLE;
        end
      end

      rcpa_pkg::S_ALLOC0: begin
        if (hit0.found) begin
          alloc_try = 1'b1;
        end else if (hit_w.found) begin
          // later words lie wholly at or above first_page
          bm_req.rd_en   = 1'b1;
          bm_req.rd_addr = hit_w.idx;
          word_next      = hit_w.idx;
          state_next     = rcpa_pkg::S_ALLOC1;
        end else begin
          resp_en     = 1'b1;
          resp_status = rcpa_pkg::STAT_NO_PAGES;
          state_next  = rcpa_pkg::S_IDLE;
        end
      end

      rcpa_pkg::S_ALLOC1: begin
        alloc_word = word_q;
        alloc_bit  = hit1.idx;
        if (hit1.found) begin
          alloc_try = 1'b1;
        end else begin
          resp_en     = 1'b1;
          resp_status = rcpa_pkg::STAT_NO_PAGES;
          state_next  = rcpa_pkg::S_IDLE;
        end
      end

      rcpa_pkg::S_REF: begin
        resp_en    = 1'b1;
        state_next = rcpa_pkg::S_IDLE;
        bit_onehot = rcpa_pkg::WORD_BITS'(1) << ref_bit;
        if (!ref_used) begin
          resp_status = rcpa_pkg::STAT_UNREF;
        end else if (op_q == rcpa_pkg::OP_RELEASE) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_dec;
          resp_cnt  = cnt_dec;
          if (cnt_dec == '0) begin
            // last reference gone: page is free again
            bm_req.wr_en   = 1'b1;
            bm_req.wr_addr = rcpa_pkg::WORD_W'(idx_q >> rcpa_pkg::BIT_W);
            bm_req.wr_data = bm_stat.rd_data & ~bit_onehot;
            if (pages_free != rcpa_pkg::REG_MAX) free_next = pages_free + 1'b1;
          end
        end else if (cnt_inc >= {1'b0, rcpa_pkg::COUNT_MAX}) begin
          resp_status = rcpa_pkg::STAT_OVERFLOW;
          resp_cnt    = cnt_eff;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_inc[rcpa_pkg::COUNT_WIDTH-1:0];
          resp_cnt  = cnt_inc[rcpa_pkg::COUNT_WIDTH-1:0];
        end
      end

      default: begin
        state_next = rcpa_pkg::S_IDLE;
      end
    endcase

    // common finish of an allocate: mark the page taken or report no pages
    if (alloc_try) begin
      alloc_page = {alloc_word, alloc_bit};
      resp_en    = 1'b1;
      state_next = rcpa_pkg::S_IDLE;
      if (rcpa_pkg::REG_W'(alloc_page) < limit) begin
        bit_onehot     = rcpa_pkg::WORD_BITS'(1) << alloc_bit;
        bm_req.wr_en   = 1'b1;
        bm_req.wr_addr = alloc_word;
        bm_req.wr_data = bm_stat.rd_data | bit_onehot;
        cnt_we         = 1'b1;
        cnt_waddr      = alloc_page;
        cnt_wdata      = rcpa_pkg::COUNT_WIDTH'(1);
        resp_page      = rcpa_pkg::IDX_W'(alloc_page);
        resp_cnt       = rcpa_pkg::COUNT_WIDTH'(1);
        if (pages_free != '0) free_next = pages_free - 1'b1;
      end else begin
        resp_status = rcpa_pkg::STAT_NO_PAGES;
      end
    end
  end

  // count store, read data registered
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rd <= cnt_mem[cnt_raddr];
  end

  // command capture and search word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= rcpa_pkg::op_t'(opcode);
      idx_q <= page_index;
    end
    word_q <= word_next;
  end

  // configuration and free counter
  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= rcpa_pkg::REG_W'(rcpa_pkg::FIRST_PAGE_RESET);
      page_count <= rcpa_pkg::REG_W'(rcpa_pkg::PAGE_COUNT_RESET);
      pages_free <= rcpa_pkg::REG_W'(rcpa_pkg::FREE_RESET);
    end else begin
      pages_free <= free_next;
      if (cfg_valid && cfg_ready) begin
        case (rcpa_pkg::reg_idx_t'(cfg_index))
          rcpa_pkg::REG_FIRST_PAGE: first_page <= cfg_data;
          rcpa_pkg::REG_PAGE_COUNT: page_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result transfer, one cycle wide
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= resp_en;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_en) begin
      status      <= resp_status;
      result_page <= resp_page;
      ref_count   <= rcpa_pkg::OUT_CNT_W'(resp_cnt);
      free_count  <= free_next;
    end
  end

endmodule

### rtl/rcpa_bitmap.sv
// occupancy bitmap: one bit per page, full flag per word, clearing sweep
module rcpa_bitmap (
  input  logic               clk,
  input  logic               rst,
  input  rcpa_pkg::bm_req_t  req,
  output rcpa_pkg::bm_stat_t stat
);

  logic [rcpa_pkg::WORD_BITS-1:0] mem [rcpa_pkg::WORDS];
  logic [rcpa_pkg::WORD_BITS-1:0] rd_data;
  logic [rcpa_pkg::WORDS-1:0]     full;
  logic                           sweep_active;
  logic [rcpa_pkg::WORD_W-1:0]    sweep_addr;

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      sweep_active <= 1'b1;
      sweep_addr   <= '0;
      full         <= '0;
    end else begin
      if (sweep_active) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == rcpa_pkg::WORD_W'(rcpa_pkg::WORDS - 1)) sweep_active <= 1'b0;
      end
      if (req.wr_en) full[req.wr_addr] <= &req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_active) begin
      mem[sweep_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end

  assign stat.rd_data  = rd_data;
  assign stat.full     = full;
  assign stat.clearing = sweep_active;

endmodule

### tb/refcounted_page_allocator_test.sv
// self-checking testbench for the page allocator with a reference count mirror
`timescale 1ns / 100ps

import rcpa_pkg::*;

// what one command is expected to answer
typedef struct {
  status_t               status;
  logic [IDX_W-1:0]      page;
  logic [OUT_CNT_W-1:0]  count;
  logic [REG_W-1:0]      free;
} page_reply_t;

// mirror of the allocator state plus the replies still owed by the block
class page_ledger;
  bit [COUNT_WIDTH-1:0] counts [PAGES];
  bit [REG_W-1:0]       free_left;
  bit [REG_W-1:0]       first_pg;
  bit [REG_W-1:0]       page_cnt;
  page_reply_t          replies_due [$];
  int                   errors;
  int                   commands;
  int                   results;
  int                   tally [5];

  function new();
    first_pg  = REG_W'(FIRST_PAGE_RESET);
    page_cnt  = REG_W'(PAGE_COUNT_RESET);
    free_left = fresh_free();
  endfunction

  // effective page count, larger settings saturate at the store size
  function int unsigned top_page();
    return (page_cnt > PAGES) ? PAGES : page_cnt;
  endfunction

  function bit [REG_W-1:0] fresh_free();
    int unsigned top;
    top = top_page();
    return (first_pg >= top) ? '0 : REG_W'(top - first_pg);
  endfunction

  function void set_reg(reg_idx_t r, bit [REG_W-1:0] v);
    if (r == REG_FIRST_PAGE) first_pg = v;
    else page_cnt = v;
  endfunction

  // random page inside the window that currently holds references
  function bit find_held(output logic [IDX_W-1:0] pg);
    int unsigned top, span, k, p;
    top = top_page();
    pg  = '0;
    if (first_pg >= top) return 0;
    span = top - first_pg;
    k    = $urandom_range(span - 1);
    for (int unsigned n = 0; n < span; n++) begin
      p = first_pg + (k + n) % span;
      if (counts[p] != 0) begin
        pg = IDX_W'(p);
        return 1;
      end
    end
    return 0;
  endfunction

  // apply one transferred command to the mirror and queue its reply
  function void take_command(op_t op, logic [IDX_W-1:0] idx);
    page_reply_t r;
    int unsigned top, p;
    top      = top_page();
    r.status = STAT_OK;
    r.page   = idx;
    r.count  = '0;
    case (op)
      OP_CLEAR: begin
        foreach (counts[k]) counts[k] = '0;
        free_left = fresh_free();
      end
      OP_ALLOC: begin
        p = first_pg;
        while (p < top && counts[p] != 0) p++;
        if (p < top) begin
          counts[p] = 1;
          if (free_left != 0) free_left--;
          r.page  = IDX_W'(p);
          r.count = 1;
        end else begin
          r.status = STAT_NO_PAGES;
        end
      end
      default: begin
        if (idx < first_pg || idx >= top) begin
          r.status = STAT_RANGE;
        end else if (counts[idx] == 0) begin
          r.status = STAT_UNREF;
        end else if (op == OP_RELEASE) begin
          counts[idx]--;
          if (counts[idx] == 0 && free_left != REG_MAX) free_left++;
          r.count = OUT_CNT_W'(counts[idx]);
        end else if (counts[idx] >= COUNT_MAX - 1) begin
          r.status = STAT_OVERFLOW;
          r.count  = OUT_CNT_W'(counts[idx]);
        end else begin
          counts[idx]++;
          r.count = OUT_CNT_W'(counts[idx]);
        end
      end
    endcase
    r.free = free_left;
    replies_due.push_back(r);
    tally[int'(r.status)]++;
    commands++;
  endfunction

  function void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  // compare one result against the oldest reply owed
  function void compare_result(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] pg,
                               logic [OUT_CNT_W-1:0] cnt, logic [REG_W-1:0] fr);
    page_reply_t w;
    results++;
    if (replies_due.size() == 0) begin
      errors++;
      $display("%0t: result with no command outstanding, expected none actual status %0d page %0d",
               $time, st, pg);
      return;
    end
    w = replies_due.pop_front();
    check_field("status", 16'(w.status), 16'(st));
    check_field("result_page", 16'(w.page), 16'(pg));
    check_field("ref_count", 16'(w.count), 16'(cnt));
    check_field("free_count", 16'(w.free), 16'(fr));
  endfunction
endclass

module refcounted_page_allocator_test;

  // a clear is the slowest command and an 86 percent idle sender the quietest one,
  // so this limit is many times the worst case
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 100;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 start      = 1'b0;
  logic [1:0]           opcode     = OP_CLEAR;
  logic [IDX_W-1:0]     page_index = '0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_FIRST_PAGE;
  logic [REG_W-1:0]     cfg_data   = '0;
  logic                 busy;
  logic                 done;
  logic                 cfg_ready;
  logic [STATUS_W-1:0]  status;
  logic [IDX_W-1:0]     result_page;
  logic [OUT_CNT_W-1:0] ref_count;
  logic [REG_W-1:0]     free_count;

  page_ledger ledger = new();
  int         sent;
  int         settings;
  int         idle_pct;
  int         quiet_cycles;

  refcounted_page_allocator i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .page_index  (page_index),
    .done        (done),
    .status      (status),
    .result_page (result_page),
    .ref_count   (ref_count),
    .free_count  (free_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results last one cycle and cannot be held off, so every done is checked at once
  always @(posedge clk) begin
    if (!rst && done) ledger.compare_result(status, result_page, ref_count, free_count);
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d replies still owed",
               $time, QUIET_LIMIT, ledger.replies_due.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one command transfer; start stays high afterwards unless the next call idles
  task automatic send_command(op_t op, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    page_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    ledger.take_command(op, idx);
    sent++;
  endtask

  // release or add reference on a page that holds references, else allocate one
  task automatic held_op(op_t op);
    logic [IDX_W-1:0] pg;
    if (ledger.find_held(pg)) send_command(op, pg);
    else send_command(OP_ALLOC, IDX_W'($urandom));
  endtask

  // wait until every reply has arrived and the block is no longer busy
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.replies_due.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [REG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.set_reg(r, v);
  endtask

  // registers change only with nothing in flight
  task automatic apply_setting(logic [REG_W-1:0] fst, logic [REG_W-1:0] cnt);
    settle();
    write_reg(REG_FIRST_PAGE, fst);
    write_reg(REG_PAGE_COUNT, cnt);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // drive one referenced page up to the count limit, then one add reference past it and one release
  task automatic saturate_page();
    logic [IDX_W-1:0] pg;
    if (!ledger.find_held(pg)) begin
      send_command(OP_ALLOC, '0);
      if (!ledger.find_held(pg)) return;
    end
    while (ledger.counts[pg] < COUNT_MAX - 1) send_command(OP_ADDREF, pg);
    send_command(OP_ADDREF, pg);
    send_command(OP_RELEASE, pg);
  endtask

  // one random sequence; mostly well-formed traffic on live pages
  task automatic random_burst();
    int               pick;
    int               n;
    int unsigned      top;
    logic [IDX_W-1:0] pg;
    pick = $urandom_range(99);
    n    = $urandom_range(1, 6);
    if (pick < 30) begin
      repeat (n) send_command(OP_ALLOC, IDX_W'($urandom));
    end else if (pick < 55) begin
      repeat (n) held_op(OP_RELEASE);
    end else if (pick < 75) begin
      repeat (n) held_op(OP_ADDREF);
    end else if (pick < 87) begin
      // noise: any operation on any index
      repeat (n) send_command(op_t'($urandom_range(3)), IDX_W'($urandom));
    end else if (pick < 97) begin
      // window edges: just below, at the bottom, at the top, just past it
      top = ledger.top_page();
      case ($urandom_range(3))
        0:       pg = IDX_W'(ledger.first_pg - 1);
        1:       pg = IDX_W'(ledger.first_pg);
        2:       pg = IDX_W'(top - 1);
        default: pg = IDX_W'(top);
      endcase
      send_command($urandom_range(1) ? OP_RELEASE : OP_ADDREF, pg);
    end else begin
      send_command(OP_CLEAR, IDX_W'($urandom));
    end
  endtask

  initial begin
    int unsigned fst;
    int unsigned cnt;
    int unsigned win;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset window of 257 up to 4096
    send_command(OP_ADDREF, 12'd300);     // never referenced
    send_command(OP_RELEASE, 12'd300);
    send_command(OP_RELEASE, 12'd256);    // just below the window
    send_command(OP_ADDREF, '1);          // top page, unreferenced
    send_command(OP_RELEASE, '0);
    send_command(OP_ALLOC, '0);
    send_command(OP_ALLOC, '1);
    send_command(OP_ADDREF, 12'd257);
    send_command(OP_RELEASE, 12'd257);
    send_command(OP_RELEASE, 12'd257);    // back to free, free count rises
    send_command(OP_ALLOC, '0);
    send_command(OP_CLEAR, '0);
    send_command(OP_ALLOC, '0);

    // directed: single page window, allocator runs dry
    apply_setting(13'd4095, 13'd4096);
    send_command(OP_CLEAR, '0);
    send_command(OP_ALLOC, '0);
    send_command(OP_ALLOC, '0);
    send_command(OP_ADDREF, 12'd4094);
    send_command(OP_RELEASE, 12'd4095);

    // directed: first page above the page count, nothing is usable
    apply_setting(13'd300, 13'd200);
    send_command(OP_CLEAR, '0);
    send_command(OP_ALLOC, '0);
    send_command(OP_RELEASE, 12'd250);
    send_command(OP_ADDREF, 12'd300);

    // random phases, each with its own window and sender idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin fst = 0;    cnt = 16;   end
        1:       begin fst = 4064; cnt = 8191; end  // count beyond the store size
        2:       begin fst = 8191; cnt = 1;    end
        3:       begin fst = 0;    cnt = 4096; end
        4:       begin fst = 257;  cnt = 4096; end
        5:       begin fst = 4095; cnt = 4096; end
        default: begin
          cnt = $urandom_range(1, 4096);
          win = $urandom_range(0, 40);
          fst = (cnt > win) ? cnt - win : 0;
          if ($urandom_range(3) == 0) fst = $urandom_range(0, 4096);
          if ($urandom_range(5) == 0) cnt = $urandom_range(1, 8191);
        end
      endcase
      apply_setting(REG_W'(fst), REG_W'(cnt));
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 86;
        default: idle_pct = 28;
      endcase
      if ($urandom_range(1)) send_command(OP_CLEAR, IDX_W'($urandom));
      if (ph == 0 || ph == 6) saturate_page();
      win = sent + PHASE_ITEMS;
      while (sent < win) random_burst();
    end

    settle();
    repeat (10) @(posedge clk);

    $display("covered %0d commands over %0d register settings, %0d results compared",
             ledger.commands, settings, ledger.results);
    $display("outcomes: ok %0d, out of pages %0d, range %0d, unreferenced %0d, overflow %0d",
             ledger.tally[STAT_OK], ledger.tally[STAT_NO_PAGES], ledger.tally[STAT_RANGE],
             ledger.tally[STAT_UNREF], ledger.tally[STAT_OVERFLOW]);
    if (ledger.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rcpa_pkg.sv
rtl/rcpa_bitmap.sv
rtl/refcounted_page_allocator.sv
tb/refcounted_page_allocator_test.sv
